@@ rtl/sobel_et_pkg.sv @@
// Shared types, widths and constants of the Sobel edge threshold block.
package sobel_et_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int CFG_SIZE_W = 11;
  localparam int CFG_THR_W  = 12;
  localparam int CFG_FILL_W = 8;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_SIZE_W-1:0] RST_IMAGE_WIDTH    = 11'd640;
  localparam logic [CFG_SIZE_W-1:0] RST_IMAGE_HEIGHT   = 11'd480;
  localparam logic [CFG_THR_W-1:0]  RST_EDGE_THRESHOLD = 12'd128;
  localparam logic [CFG_FILL_W-1:0] RST_FILL_VALUE     = 8'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH    = 2'd0,
    REG_IMAGE_HEIGHT   = 2'd1,
    REG_EDGE_THRESHOLD = 2'd2,
    REG_FILL_VALUE     = 2'd3
  } cfg_reg_t;

  localparam logic REQ_PAD = 1'b1;

  // Channel sum r+g+b, gradient, squared gradient and magnitude widths.
  localparam int SUM_W  = 10;
  localparam int GRAD_W = 13;
  localparam int SQ_W   = 24;
  localparam int MAG_W  = 25;

  localparam logic [7:0] EDGE_VALUE = 8'd255;

  localparam int MQ_DEPTH = 4;
  localparam int OQ_DEPTH = 2;

  // Masked 3x3 window, index col*3+row, col 0 leftmost, row 0 topmost.
  typedef struct packed {
    logic [8:0][SUM_W-1:0] win;
    logic                  last;
  } job_t;

  typedef struct packed {
    logic       edge_res;
    logic [7:0] pixel_value;
    logic       frame_last;
  } res_t;

endpackage

@@ rtl/sobel_edge_threshold.sv @@
// Sobel edge threshold block: top level with configuration registers and queues.
//
// Pixels enter in raster order through a queue-style port: an item is taken
// on a clock edge with push high and full low. req_type low marks a frame
// pixel, high a pad item; after the last pixel of a frame, image_width + 1
// items (pads) release the remaining results. Results leave through a second
// queue-style port: the oldest result is on edge_res, pixel_value and
// frame_last while empty is low, and it is taken on an edge with pop high.
// The result for frame position k is released by the item at stream position
// k + image_width + 1; it then passes the front stage, the job queue, the
// gradient, square and compare stages and the result queue. One item per
// clock is sustained as long as full stays low.
// When the receiver stalls, the result queue and then the queue between the
// front and the gradient pipeline fill, and full rises once both are held.
// Configuration is written through cfg_we, cfg_index and cfg_data while the
// block is idle, a rule for the user that the block does not enforce. Reset
// empties every queue and pipeline stage, returns the frame counters to the
// start of a frame, loads defaults 640 x 480, threshold 128 and fill value 0.
module sobel_edge_threshold #(
  parameter int MAX_WIDTH  = sobel_et_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sobel_et_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [sobel_et_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sobel_et_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                                push,
  output logic                                full,
  input  logic                                req_type,
  input  logic [7:0]                          red,
  input  logic [7:0]                          green,
  input  logic [7:0]                          blue,
  output logic                                empty,
  input  logic                                pop,
  output logic                                edge_res,
  output logic [7:0]                          pixel_value,
  output logic                                frame_last
);

  localparam int JW = $bits(sobel_et_pkg::job_t);
  localparam int RSW = $bits(sobel_et_pkg::res_t);

  logic [sobel_et_pkg::CFG_SIZE_W-1:0] image_width;
  logic [sobel_et_pkg::CFG_SIZE_W-1:0] image_height;
  logic [sobel_et_pkg::CFG_THR_W-1:0]  edge_threshold;
  logic [sobel_et_pkg::CFG_FILL_W-1:0] fill_value;

  logic               mq_push;
  logic               mq_full;
  logic               mq_pop;
  logic               mq_empty;
  sobel_et_pkg::job_t mq_din;
  sobel_et_pkg::job_t mq_dout;

  logic               oq_push;
  logic               oq_full;
  sobel_et_pkg::res_t oq_din;
  sobel_et_pkg::res_t oq_dout;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= sobel_et_pkg::RST_IMAGE_WIDTH;
      image_height   <= sobel_et_pkg::RST_IMAGE_HEIGHT;
      edge_threshold <= sobel_et_pkg::RST_EDGE_THRESHOLD;
      fill_value     <= sobel_et_pkg::RST_FILL_VALUE;
    end else if (cfg_we) begin
      case (sobel_et_pkg::cfg_reg_t'(cfg_index))
        sobel_et_pkg::REG_IMAGE_WIDTH: begin
          image_width <= cfg_data[sobel_et_pkg::CFG_SIZE_W-1:0];
        end
        sobel_et_pkg::REG_IMAGE_HEIGHT: begin
          image_height <= cfg_data[sobel_et_pkg::CFG_SIZE_W-1:0];
        end
        sobel_et_pkg::REG_EDGE_THRESHOLD: begin
          edge_threshold <= cfg_data[sobel_et_pkg::CFG_THR_W-1:0];
        end
        sobel_et_pkg::REG_FILL_VALUE: begin
          fill_value <= cfg_data[sobel_et_pkg::CFG_FILL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  sobel_et_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_width  (image_width),
    .cfg_height (image_height),
    .push       (push),
    .full       (full),
    .req_type   (req_type),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .q_push     (mq_push),
    .q_job      (mq_din),
    .q_full     (mq_full)
  );

  sobel_et_fifo #(
    .WIDTH (JW),
    .DEPTH (sobel_et_pkg::MQ_DEPTH)
  ) u_job_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (mq_push),
    .din   (mq_din),
    .full  (mq_full),
    .pop   (mq_pop),
    .dout  (mq_dout),
    .empty (mq_empty)
  );

  sobel_et_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_threshold (edge_threshold),
    .cfg_fill      (fill_value),
    .q_empty       (mq_empty),
    .q_pop         (mq_pop),
    .q_job         (mq_dout),
    .o_full        (oq_full),
    .o_push        (oq_push),
    .o_res         (oq_din)
  );

  sobel_et_fifo #(
    .WIDTH (RSW),
    .DEPTH (sobel_et_pkg::OQ_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (oq_push),
    .din   (oq_din),
    .full  (oq_full),
    .pop   (pop),
    .dout  (oq_dout),
    .empty (empty)
  );

  assign edge_res    = oq_dout.edge_res;
  assign pixel_value = oq_dout.pixel_value;
  assign frame_last  = oq_dout.frame_last;

  // The front only pushes a window into the job queue when it has room.
  assert property (@(posedge clk) disable iff (rst) mq_push |-> !mq_full)
    else $error("job queue written while full");

  // The back only hands a result over when the result queue has room.
  assert property (@(posedge clk) disable iff (rst) oq_push |-> !oq_full)
    else $error("result queue written while full");

  // Input back-pressure only comes from a full job queue.
  assert property (@(posedge clk) disable iff (rst) full |-> mq_full)
    else $error("input held off while the job queue has room");

  // The back drains the job queue whenever the result side is free.
  assert property (@(posedge clk) disable iff (rst) (!mq_empty && !oq_full) |-> mq_pop)
    else $error("job queue not drained");

endmodule

@@ rtl/sobel_et_fifo.sv @@
// Small register queue used between the front and back and on the result side.
module sobel_et_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == NW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + NW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - NW'(1);
      end
    end
  end

endmodule

@@ rtl/sobel_et_front.sv @@
// Front part: frame position tracking, line stores and the 3x3 window of channel sums.
module sobel_et_front #(
  parameter int MAX_WIDTH  = sobel_et_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sobel_et_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [sobel_et_pkg::CFG_SIZE_W-1:0]  cfg_width,
  input  logic [sobel_et_pkg::CFG_SIZE_W-1:0]  cfg_height,
  input  logic                                 push,
  output logic                                 full,
  input  logic                                 req_type,
  input  logic [7:0]                           red,
  input  logic [7:0]                           green,
  input  logic [7:0]                           blue,
  output logic                                 q_push,
  output sobel_et_pkg::job_t                   q_job,
  input  logic                                 q_full
);

  localparam int SW = sobel_et_pkg::SUM_W;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT + 3);
  localparam int OW = $clog2(MAX_HEIGHT);
  localparam int AW = (CW > RW) ? CW : RW;
  localparam int BW = (AW > sobel_et_pkg::CFG_SIZE_W) ? AW : sobel_et_pkg::CFG_SIZE_W;
  localparam int KW = BW + 2;

  // Frame counters.
  logic [CW-1:0] in_column, in_column_next;
  logic [RW-1:0] in_row, in_row_next;
  logic [CW-1:0] out_column, out_column_next;
  logic [OW-1:0] out_row, out_row_next;

  // Stage 1: item waiting to update the stores and the window.
  logic          s1_valid;
  logic          s1_active;
  logic          s1_last;
  logic [CW-1:0] s1_col;
  logic [SW-1:0] s1_sum;
  logic [CW-1:0] s1_ocol;
  logic [OW-1:0] s1_orow;
  logic [SW-1:0] up_rd;
  logic [SW-1:0] lo_rd;
  logic          fwd;
  logic [SW-1:0] fwd_top;
  logic [SW-1:0] fwd_mid;

  logic [SW-1:0] line_upper [MAX_WIDTH];
  logic [SW-1:0] line_lower [MAX_WIDTH];

  logic [8:0][SW-1:0] win;
  logic [8:0][SW-1:0] win_next;

  logic [KW-1:0] w_k;
  logic [KW-1:0] h_k;
  logic          clr;
  logic [CW-1:0] ic;
  logic [RW-1:0] ir;
  logic [CW-1:0] oc;
  logic [OW-1:0] orow;
  logic          accept;
  logic          flush;
  logic          take;
  logic [SW-1:0] sum;
  logic          active;
  logic          col_end;
  logic          ocol_end;
  logic          last;
  logic          s1_go;
  logic [SW-1:0] top;
  logic [SW-1:0] mid;
  logic [2:0]    row_ok;
  logic [2:0]    col_ok;

  // Sizes of 0 count as 1, sizes above the maximum saturate.
  always_comb begin
    if (cfg_width == '0) begin
      w_k = KW'(1);
    end else if (KW'(cfg_width) > KW'(MAX_WIDTH)) begin
      w_k = KW'(MAX_WIDTH);
    end else begin
      w_k = KW'(cfg_width);
    end
    if (cfg_height == '0) begin
      h_k = KW'(1);
    end else if (KW'(cfg_height) > KW'(MAX_HEIGHT)) begin
      h_k = KW'(MAX_HEIGHT);
    end else begin
      h_k = KW'(cfg_height);
    end
  end

  // A counter outside the current size abandons the frame in progress.
  assign clr = (KW'(in_row) > h_k + KW'(1)) || (KW'(in_column) >= w_k) ||
               (KW'(out_row) >= h_k) || (KW'(out_column) >= w_k);
  assign ic   = clr ? '0 : in_column;
  assign ir   = clr ? '0 : in_row;
  assign oc   = clr ? '0 : out_column;
  assign orow = clr ? '0 : out_row;

  assign s1_go  = s1_valid && !(s1_active && q_full);
  assign full   = s1_valid && s1_active && q_full;
  assign accept = push && !full;
  assign flush  = (KW'(ir) >= h_k);
  // A pad item before the frame is complete is dropped.
  assign take   = accept && (flush || (req_type != sobel_et_pkg::REQ_PAD));
  assign sum    = flush ? '0 : ({2'b00, red} + {2'b00, green} + {2'b00, blue});
  assign active = (KW'(ir) >= KW'(2)) || ((KW'(ir) == KW'(1)) && (ic != '0));
  assign col_end  = (KW'(ic) + KW'(1) >= w_k);
  assign ocol_end = (KW'(oc) + KW'(1) >= w_k);
  assign last     = (KW'(orow) + KW'(1) == h_k) && (KW'(oc) + KW'(1) == w_k);

  always_comb begin
    in_column_next  = in_column;
    in_row_next     = in_row;
    out_column_next = out_column;
    out_row_next    = out_row;
    if (accept) begin
      in_column_next  = ic;
      in_row_next     = ir;
      out_column_next = oc;
      out_row_next    = orow;
      if (take) begin
        if (col_end) begin
          in_column_next = '0;
          in_row_next    = ir + RW'(1);
        end else begin
          in_column_next = ic + CW'(1);
        end
        if (active) begin
          if (last) begin
            in_column_next  = '0;
            in_row_next     = '0;
            out_column_next = '0;
            out_row_next    = '0;
          end else if (ocol_end) begin
            out_column_next = '0;
            out_row_next    = orow + OW'(1);
          end else begin
            out_column_next = oc + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
      s1_valid   <= 1'b0;
      fwd        <= 1'b0;
    end else begin
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
      s1_valid   <= take || (s1_valid && !s1_go);
      if (take) begin
        // The item ahead writes the same column in this cycle when the row is one pixel wide.
        fwd <= s1_valid && (s1_col == ic);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_active <= active;
      s1_last   <= last;
      s1_col    <= ic;
      s1_sum    <= sum;
      s1_ocol   <= oc;
      s1_orow   <= orow;
      fwd_top   <= mid;
      fwd_mid   <= s1_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      line_upper[s1_col] <= mid;
      line_lower[s1_col] <= s1_sum;
    end
    if (take) begin
      up_rd <= line_upper[ic];
      lo_rd <= line_lower[ic];
    end
  end

  assign top = fwd ? fwd_top : up_rd;
  assign mid = fwd ? fwd_mid : lo_rd;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      win_next[k] = win[k + 3];
    end
    win_next[6] = top;
    win_next[7] = mid;
    win_next[8] = s1_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (s1_go) begin
      win <= win_next;
    end
  end

  // Neighbors outside the frame count as zero.
  assign row_ok = {(KW'(s1_orow) + KW'(1) < h_k), 1'b1, (s1_orow != '0)};
  assign col_ok = {(KW'(s1_ocol) + KW'(1) < w_k), 1'b1, (s1_ocol != '0)};

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        q_job.win[j * 3 + i] = (row_ok[i] && col_ok[j]) ? win_next[j * 3 + i] : '0;
      end
    end
    q_job.last = s1_last;
  end

  assign q_push = s1_valid && s1_active && !q_full;

endmodule

@@ rtl/sobel_et_back.sv @@
// Back part: Sobel gradients, squared magnitude and the threshold compare.
module sobel_et_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [sobel_et_pkg::CFG_THR_W-1:0]  cfg_threshold,
  input  logic [sobel_et_pkg::CFG_FILL_W-1:0] cfg_fill,
  input  logic                                q_empty,
  output logic                                q_pop,
  input  sobel_et_pkg::job_t                  q_job,
  input  logic                                o_full,
  output logic                                o_push,
  output sobel_et_pkg::res_t                  o_res
);

  localparam int GW = sobel_et_pkg::GRAD_W;
  localparam int QW = sobel_et_pkg::SQ_W;
  localparam int MW = sobel_et_pkg::MAG_W;
  localparam int TW = sobel_et_pkg::CFG_THR_W + 1;

  logic en;

  logic                 b1_valid;
  logic                 b1_last;
  logic signed [GW-1:0] b1_gx;
  logic signed [GW-1:0] b1_gy;

  logic          b2_valid;
  logic          b2_last;
  logic [QW-1:0] b2_sqx;
  logic [QW-1:0] b2_sqy;

  logic               b3_valid;
  sobel_et_pkg::res_t b3_res;

  logic [MW-1:0] lim;
  logic [TW-1:0] thr1;
  logic [2*TW-1:0] lim_prod;

  logic [GW-1:0] left_sum;
  logic [GW-1:0] right_sum;
  logic [GW-1:0] upper_sum;
  logic [GW-1:0] lower_sum;
  logic signed [2*GW-1:0] px;
  logic signed [2*GW-1:0] py;
  logic [MW-1:0] mag;
  logic          is_edge;

  assign en     = !(b3_valid && o_full);
  assign q_pop  = en && !q_empty;
  assign o_push = b3_valid && !o_full;
  assign o_res  = b3_res;

  // floor(sqrt(m)) > t is the same as m >= (t+1)^2.
  assign thr1     = {1'b0, cfg_threshold} + TW'(1);
  assign lim_prod = thr1 * thr1;

  always_ff @(posedge clk) begin
    lim <= lim_prod[MW-1:0];
  end

  // Column and row weighted sums of the window, weights 1, 2, 1.
  always_comb begin
    left_sum  = GW'(q_job.win[0]) + (GW'(q_job.win[1]) << 1) + GW'(q_job.win[2]);
    right_sum = GW'(q_job.win[6]) + (GW'(q_job.win[7]) << 1) + GW'(q_job.win[8]);
    upper_sum = GW'(q_job.win[0]) + (GW'(q_job.win[3]) << 1) + GW'(q_job.win[6]);
    lower_sum = GW'(q_job.win[2]) + (GW'(q_job.win[5]) << 1) + GW'(q_job.win[8]);
  end

  assign px      = b1_gx * b1_gx;
  assign py      = b1_gy * b1_gy;
  assign mag     = {1'b0, b2_sqx} + {1'b0, b2_sqy};
  assign is_edge = (mag >= lim);

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      b2_valid <= 1'b0;
      b3_valid <= 1'b0;
    end else if (en) begin
      b1_valid <= !q_empty;
      b2_valid <= b1_valid;
      b3_valid <= b2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_gx   <= signed'(right_sum - left_sum);
      b1_gy   <= signed'(lower_sum - upper_sum);
      b1_last <= q_job.last;
      b2_sqx  <= px[QW-1:0];
      b2_sqy  <= py[QW-1:0];
      b2_last <= b1_last;
      b3_res.edge_res    <= is_edge;
      b3_res.pixel_value <= is_edge ? sobel_et_pkg::EDGE_VALUE : cfg_fill;
      b3_res.frame_last  <= b2_last;
    end
  end

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the Sobel edge threshold block.
module tb_top;

  localparam logic REQ_PIXEL      = 1'b0;
  localparam int   SW             = sobel_et_pkg::SUM_W;
  localparam int   SETTLE_CYCLES  = 12;
  localparam int   LONG_HOLD      = 200;
  localparam int   WATCHDOG_LIMIT = 4000;
  localparam int   RANDOM_ITEMS   = 450;
  localparam int   WIDE_PIXELS    = 48;

  typedef enum int {PAT_NOISE, PAT_BLOCKS, PAT_RAMP, PAT_EXTREME} pattern_t;

  // Tracks the frame state of the block, predicts the result of every item
  // and compares the results that come out against those predictions.
  class edge_mark_board;
    logic [sobel_et_pkg::CFG_SIZE_W-1:0] width_reg, height_reg;
    logic [sobel_et_pkg::CFG_THR_W-1:0]  thr_reg;
    logic [sobel_et_pkg::CFG_FILL_W-1:0] fill_reg;
    logic [SW-1:0]        upper_row [sobel_et_pkg::DEF_MAX_WIDTH];
    logic [SW-1:0]        lower_row [sobel_et_pkg::DEF_MAX_WIDTH];
    logic [SW-1:0]        win [9];
    int unsigned          in_col, in_row, out_col, out_row;
    sobel_et_pkg::res_t   marks_due [$];
    int                   fails, items_fed, pixels_fed, results, edges, frames;

    function new();
      width_reg  = sobel_et_pkg::RST_IMAGE_WIDTH;
      height_reg = sobel_et_pkg::RST_IMAGE_HEIGHT;
      thr_reg    = sobel_et_pkg::RST_EDGE_THRESHOLD;
      fill_reg   = sobel_et_pkg::RST_FILL_VALUE;
      for (int i = 0; i < sobel_et_pkg::DEF_MAX_WIDTH; i++) begin
        upper_row[i] = '0;
        lower_row[i] = '0;
      end
      for (int i = 0; i < 9; i++) win[i] = '0;
      restart();
    endfunction

    function void restart();
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
    endfunction

    function int unsigned span(int unsigned v, int unsigned lim);
      if (v < 1) return 1;
      if (v > lim) return lim;
      return v;
    endfunction

    function void set_reg(sobel_et_pkg::cfg_reg_t idx,
                          logic [sobel_et_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        sobel_et_pkg::REG_IMAGE_WIDTH:    width_reg  = val[sobel_et_pkg::CFG_SIZE_W-1:0];
        sobel_et_pkg::REG_IMAGE_HEIGHT:   height_reg = val[sobel_et_pkg::CFG_SIZE_W-1:0];
        sobel_et_pkg::REG_EDGE_THRESHOLD: thr_reg    = val[sobel_et_pkg::CFG_THR_W-1:0];
        sobel_et_pkg::REG_FILL_VALUE:     fill_reg   = val[sobel_et_pkg::CFG_FILL_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return marks_due.size();
    endfunction

    function void feed_item(logic kind, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int unsigned        w, h, c, t, mag, lim;
      logic [SW-1:0]      chan_sum, top, mid;
      int                 gx, gy, v, rr, cc;
      bit                 active, hit, last;
      sobel_et_pkg::res_t mark;
      w = span(int'(width_reg), sobel_et_pkg::DEF_MAX_WIDTH);
      h = span(int'(height_reg), sobel_et_pkg::DEF_MAX_HEIGHT);
      items_fed++;
      if (kind == REQ_PIXEL) pixels_fed++;
      // A size change can leave the counters outside the frame; start over then.
      if (in_row > h + 1 || in_col >= w || out_row >= h || out_col >= w) restart();
      chan_sum = '0;
      if (in_row < h) begin
        if (kind == sobel_et_pkg::REQ_PAD) return;
        chan_sum = SW'(r) + SW'(g) + SW'(b);
      end
      c = in_col;
      top = upper_row[c];
      mid = lower_row[c];
      upper_row[c] = mid;
      lower_row[c] = chan_sum;
      for (int i = 0; i < 6; i++) win[i] = win[i + 3];
      win[6] = top;
      win[7] = mid;
      win[8] = chan_sum;
      active = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      if (!active) return;

      // The window is centred on the output position; taps off the frame are zero.
      gx = 0;
      gy = 0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          rr = int'(out_row) - 1 + i;
          cc = int'(out_col) - 1 + j;
          if (rr >= 0 && rr < int'(h) && cc >= 0 && cc < int'(w)) begin
            v = int'(win[j * 3 + i]);
            gx += v * (j - 1) * ((i == 1) ? 2 : 1);
            gy += v * (i - 1) * ((j == 1) ? 2 : 1);
          end
        end
      end
      t = int'(thr_reg);
      mag = gx * gx + gy * gy;
      lim = (t + 1) * (t + 1);
      hit = (mag >= lim);
      last = (out_row == h - 1) && (out_col == w - 1);
      mark.edge_res    = hit;
      mark.pixel_value = hit ? sobel_et_pkg::EDGE_VALUE : fill_reg;
      mark.frame_last  = last;
      marks_due.push_back(mark);
      if (last) begin
        restart();
      end else begin
        out_col++;
        if (out_col >= w) begin
          out_col = 0;
          out_row++;
        end
      end
    endfunction

    function void check_mark(logic hit, logic [7:0] value, logic last);
      sobel_et_pkg::res_t want;
      if (marks_due.size() == 0) begin
        $error("result with nothing expected: edge_res=%0b pixel_value=%0d frame_last=%0b",
               hit, value, last);
        fails++;
        return;
      end
      want = marks_due.pop_front();
      results++;
      if (want.edge_res) edges++;
      if (want.frame_last) frames++;
      if (hit !== want.edge_res) begin
        $error("edge_res: expected %0b, got %0b", want.edge_res, hit);
        fails++;
      end
      if (value !== want.pixel_value) begin
        $error("pixel_value: expected %0d, got %0d", want.pixel_value, value);
        fails++;
      end
      if (last !== want.frame_last) begin
        $error("frame_last: expected %0b, got %0b", want.frame_last, last);
        fails++;
      end
    endfunction
  endclass

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                cfg_we = 1'b0;
  logic [sobel_et_pkg::CFG_IDX_W-1:0]  cfg_index = sobel_et_pkg::REG_IMAGE_WIDTH;
  logic [sobel_et_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                                push = 1'b0;
  logic                                full;
  logic                                req_type = REQ_PIXEL;
  logic [7:0]                          red = '0, green = '0, blue = '0;
  logic                                empty;
  logic                                pop = 1'b0;
  logic                                edge_res;
  logic [7:0]                          pixel_value;
  logic                                frame_last;

  edge_mark_board marks;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  bit long_hold_req = 1'b0;
  int long_holds = 0;
  int settings = 0;
  int quiet_cycles = 0;
  int full_cycles = 0;

  sobel_edge_threshold dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full),
    .req_type(req_type), .red(red), .green(green), .blue(blue),
    .empty(empty), .pop(pop),
    .edge_res(edge_res), .pixel_value(pixel_value), .frame_last(frame_last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (push && full) full_cycles <= full_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timed out after %0d cycles without progress.", quiet_cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: random pops, bursts without gaps and one long hold-off.
  initial begin : result_side
    int gap;
    while (rst) @(negedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        pop = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_holds++;
      end
      gap = rx_burst ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        pop = 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop = 1'b1;
      do @(posedge clk); while (empty);
      marks.check_mark(edge_res, pixel_value, frame_last);
      @(negedge clk);
      if ($urandom_range(0, 63) == 0) rx_burst = !rx_burst;
    end
  end

  task automatic send_item(logic kind, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    push = 1'b1;
    req_type = kind;
    red = r;
    green = g;
    blue = b;
    do @(posedge clk); while (full);
    marks.feed_item(kind, r, g, b);
    @(negedge clk);
  endtask

  task automatic wait_results();
    push = 1'b0;
    while (marks.pending() != 0) @(negedge clk);
  endtask

  // A pad may still be in the pipeline after the last result, so wait a little more.
  task automatic settle();
    wait_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(sobel_et_pkg::cfg_reg_t idx, int val);
    push = 1'b0;
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val[sobel_et_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    marks.set_reg(idx, val[sobel_et_pkg::CFG_DATA_W-1:0]);
  endtask

  task automatic configure(int wv, int hv, int thr, int fillv);
    write_reg(sobel_et_pkg::REG_IMAGE_WIDTH, wv);
    write_reg(sobel_et_pkg::REG_IMAGE_HEIGHT, hv);
    write_reg(sobel_et_pkg::REG_EDGE_THRESHOLD, thr);
    write_reg(sobel_et_pkg::REG_FILL_VALUE, fillv);
    settings++;
  endtask

  function automatic logic [23:0] make_pixel(pattern_t mode, int row, int col);
    logic [23:0] noise;
    logic [7:0]  base;
    noise = 24'($urandom);
    case (mode)
      PAT_BLOCKS: begin
        base = (((row / 2) + (col / 3)) % 2 != 0) ? 8'd230 : 8'd20;
        return {base + noise[3:0], base + noise[7:4], base + noise[11:8]};
      end
      PAT_RAMP: begin
        base = 8'(col * 29 + row * 13);
        return {base, base, base + 8'(noise[1:0])};
      end
      PAT_EXTREME: return {{8{noise[0]}}, {8{noise[1]}}, {8{noise[2]}}};
      default: return noise;
    endcase
  endfunction

  function automatic int pick_threshold();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 4095;
      2: return $urandom_range(0, 4095);
      default: return $urandom_range(0, 1200);
    endcase
  endfunction

  // Pads sprinkled into the frame must be ignored by the block.
  task automatic send_frame(int w, pattern_t mode, int count, bit pause_mid);
    logic [23:0] px;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 24) == 0) begin
        px = 24'($urandom);
        send_item(sobel_et_pkg::REQ_PAD, px[23:16], px[15:8], px[7:0]);
      end
      if (pause_mid && k == count / 2) wait_results();
      px = make_pixel(mode, k / w, k % w);
      send_item(REQ_PIXEL, px[23:16], px[15:8], px[7:0]);
    end
  endtask

  // Pixels offered during the flush count as pads; a trailing pad is ignored.
  task automatic flush(int w);
    logic [23:0] px;
    for (int k = 0; k <= w; k++) begin
      px = 24'($urandom);
      send_item(($urandom_range(0, 5) == 0) ? REQ_PIXEL : sobel_et_pkg::REQ_PAD,
                px[23:16], px[15:8], px[7:0]);
    end
    if ($urandom_range(0, 3) == 0) begin
      px = 24'($urandom);
      send_item(sobel_et_pkg::REQ_PAD, px[23:16], px[15:8], px[7:0]);
    end
  endtask

  task automatic random_phase();
    int       sel, wv, hv, w, h, count;
    bit       abandon;
    pattern_t mode;
    sel = $urandom_range(0, 9);
    wv = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(17, 40) : $urandom_range(1, 16);
    sel = $urandom_range(0, 9);
    hv = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(11, 24) : $urandom_range(1, 10);
    configure(wv, hv, pick_threshold(), $urandom_range(0, 255));
    w = (wv == 0) ? 1 : wv;
    h = (hv == 0) ? 1 : hv;
    mode = pattern_t'($urandom_range(0, 3));
    // Now and then the frame is cut short and the next size change abandons it.
    abandon = ($urandom_range(0, 7) == 0);
    count = abandon ? $urandom_range(1, w * h) : w * h;
    tx_burst = ($urandom_range(0, 3) == 0);
    send_frame(w, mode, count, $urandom_range(0, 7) == 0);
    if (!abandon) flush(w);
    settle();
  endtask

  initial begin : stimulus
    int goal;
    marks = new();
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Small frame with extreme channels, a pad inside the frame and a pixel in the flush.
    configure(3, 3, 100, 8'h5A);
    send_item(REQ_PIXEL, 8'd0, 8'd0, 8'd0);
    send_item(REQ_PIXEL, 8'd255, 8'd255, 8'd255);
    send_item(REQ_PIXEL, 8'd255, 8'd0, 8'd0);
    send_item(sobel_et_pkg::REQ_PAD, 8'd255, 8'd255, 8'd255);
    send_item(REQ_PIXEL, 8'd0, 8'd255, 8'd0);
    send_item(REQ_PIXEL, 8'd0, 8'd0, 8'd255);
    send_item(REQ_PIXEL, 8'd255, 8'd255, 8'd255);
    send_item(REQ_PIXEL, 8'd0, 8'd0, 8'd0);
    send_item(REQ_PIXEL, 8'd170, 8'd85, 8'd1);
    send_item(REQ_PIXEL, 8'd255, 8'd255, 8'd255);
    send_item(sobel_et_pkg::REQ_PAD, 8'd0, 8'd0, 8'd0);
    send_item(REQ_PIXEL, 8'd1, 8'd2, 8'd3);
    send_item(sobel_et_pkg::REQ_PAD, 8'd0, 8'd0, 8'd0);
    send_item(sobel_et_pkg::REQ_PAD, 8'd0, 8'd0, 8'd0);
    send_item(sobel_et_pkg::REQ_PAD, 8'd0, 8'd0, 8'd0);
    settle();

    // A zero width is taken as one; with threshold zero the smallest gradient is an edge.
    configure(0, 2, 0, 8'hFF);
    send_item(REQ_PIXEL, 8'd0, 8'd0, 8'd0);
    send_item(REQ_PIXEL, 8'd0, 8'd0, 8'd1);
    send_item(sobel_et_pkg::REQ_PAD, 8'd0, 8'd0, 8'd0);
    send_item(sobel_et_pkg::REQ_PAD, 8'd0, 8'd0, 8'd0);
    settle();

    configure(2, 2, 4095, 0);
    send_item(REQ_PIXEL, 8'd0, 8'd0, 8'd0);
    send_item(REQ_PIXEL, 8'd255, 8'd255, 8'd255);
    send_item(REQ_PIXEL, 8'd255, 8'd255, 8'd255);
    send_item(REQ_PIXEL, 8'd0, 8'd0, 8'd0);
    flush(2);
    settle();

    // An oversized width saturates to the widest row; the frame is cut short
    // and the following size change abandons it.
    configure(2047, 2, pick_threshold(), 0);
    send_frame(sobel_et_pkg::DEF_MAX_WIDTH, PAT_BLOCKS, WIDE_PIXELS, 1'b0);
    settle();

    // An oversized height saturates to the tallest frame, one pixel per row.
    configure(1, 2047, pick_threshold(), 255);
    send_frame(1, PAT_RAMP, sobel_et_pkg::DEF_MAX_HEIGHT, 1'b0);
    flush(1);
    settle();

    // The result side holds off while items keep coming, so the block fills up;
    // halfway through the sender waits for every result.
    configure(8, 20, 300, 8'h33);
    long_hold_req = 1'b1;
    tx_burst = 1'b1;
    send_frame(8, PAT_BLOCKS, 160, 1'b1);
    flush(8);
    settle();

    goal = marks.items_fed + RANDOM_ITEMS;
    while (marks.items_fed < goal) random_phase();

    push = 1'b0;
    settle();
    $display("Sent %0d items (%0d pixels) over %0d register settings; checked %0d results,",
             marks.items_fed, marks.pixels_fed, settings, marks.results);
    $display("%0d edges, %0d whole frames, %0d cycles with input held off, %0d long stalls.",
             marks.edges, marks.frames, full_cycles, long_holds);
    if (marks.fails == 0 && marks.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
